>>> rtl/tlfs_pkg.sv
// Shared codes and types for the timed light fade scheduler.
package tlfs_pkg;

   localparam logic [1:0] ACT_SCHED  = 2'd0;
   localparam logic [1:0] ACT_UPDATE = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;
   localparam logic [1:0] ACT_RSVD   = 2'd3;

   localparam logic [1:0] TGT_OFF      = 2'd0;
   localparam logic [1:0] TGT_ON       = 2'd1;
   localparam logic [1:0] TGT_FADE_ON  = 2'd2;
   localparam logic [1:0] TGT_FADE_OFF = 2'd3;

   localparam logic [1:0] STS_OFF = 2'd0;
   localparam logic [1:0] STS_ON  = 2'd1;

   localparam logic [2:0] KIND_SCHEDULED = 3'd0;
   localparam logic [2:0] KIND_REJECTED  = 3'd1;
   localparam logic [2:0] KIND_DRIVE     = 3'd2;
   localparam logic [2:0] KIND_NONE      = 3'd3;
   localparam logic [2:0] KIND_CLEARED   = 3'd4;

   typedef struct packed {
      logic [31:0] t_start;
      logic [31:0] t_stop;
      logic [2:0]  light;
      logic [1:0]  target;
   } evt_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [2:0] light;
      logic [7:0] level;
      logic       pwm;
      logic [1:0] status;
      logic [4:0] count;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic done;
   } div_ctl_type;

endpackage

>>> rtl/timed_light_fade_scheduler.sv
// Timed light fade scheduler: an in-order event queue in a single-port memory, walked by a
// small sequencer. An update reads each queued event in turn and hands each result over;
// a started fade before its end adds a multiply step and a serial division. The block
// takes no new item until the last result of the current one is in the output register.
module timed_light_fade_scheduler #(
   parameter int EVENT_DEPTH = 16,
   parameter int LEVEL_MAX   = 255
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [2:0]  req_light_index,
   input  logic [31:0] req_start_time,
   input  logic [31:0] req_end_time,
   input  logic [1:0]  req_target,
   input  logic [31:0] req_now,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [2:0]  rsp_drive_light,
   output logic [7:0]  rsp_drive_level,
   output logic        rsp_is_pwm,
   output logic [1:0]  rsp_light_status,
   output logic [4:0]  rsp_executed_count,
   output logic        rsp_last
);
   import tlfs_pkg::*;

   localparam int IW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
   localparam int CW = $clog2(EVENT_DEPTH + 1);
   localparam int QW = (LEVEL_MAX > 1) ? $clog2(LEVEL_MAX + 1) : 1;
   localparam logic [QW-1:0] LMAX = QW'(LEVEL_MAX);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RD   = 3'd1;
   localparam logic [2:0] ST_EV   = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_DIVS = 3'd4;
   localparam logic [2:0] ST_DIVW = 3'd5;
   localparam logic [2:0] ST_PUSH = 3'd6;
   localparam logic [2:0] ST_FIN  = 3'd7;

   evt_type mem [EVENT_DEPTH];
   evt_type mem_q_ff;

   logic [2:0]     state_ff;
   logic [CW-1:0]  len_ff, r_ff, w_ff, count_ff;
   logic           head_ff;
   logic [31:0]    now_ff;
   logic           pend_valid_ff;
   rsp_type        pend_ff;
   logic           out_valid_ff;
   logic           out_last_ff;
   rsp_type        out_ff;
   logic [31+QW:0] num_ff;
   logic [31:0]    span_ff;

   div_ctl_type    div_ctl;
   logic [QW-1:0]  quo;

   logic           req_take, out_free, started, fin, fade, drop, push_go, out_load;
   logic           mem_we;
   logic [IW-1:0]  mem_wa;
   evt_type        mem_wd;
   evt_type        req_evt;
   rsp_type        new_rsp;
   logic [QW-1:0]  lvl;
   logic [QW+7:0]  lvl_ext;

   function automatic rsp_type kind_only(input logic [2:0] k);
      rsp_type r;
      r      = '0;
      r.kind = k;
      return r;
   endfunction

   assign req_stall = state_ff != ST_IDLE;
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !out_valid_ff || !rsp_stall;

   assign started = now_ff >= mem_q_ff.t_start;
   assign fin     = now_ff >= mem_q_ff.t_stop;
   assign fade    = mem_q_ff.target == TGT_FADE_ON || mem_q_ff.target == TGT_FADE_OFF;
   // head of the queue survives when now equals its end
   assign drop    = head_ff ? (now_ff > mem_q_ff.t_stop) : fin;
   assign push_go = state_ff == ST_PUSH && (!pend_valid_ff || out_free);
   assign out_load = (push_go && pend_valid_ff) || (state_ff == ST_FIN && out_free);

   always_comb begin
      lvl = '0;
      if (fin) begin
         if (mem_q_ff.target == TGT_ON || mem_q_ff.target == TGT_FADE_ON) begin
            lvl = LMAX;
         end
      end else if (mem_q_ff.target == TGT_FADE_ON) begin
         lvl = quo;
      end else if (mem_q_ff.target == TGT_FADE_OFF) begin
         lvl = LMAX - quo;
      end
   end
   assign lvl_ext = {8'd0, lvl};

   always_comb begin
      new_rsp.kind  = KIND_DRIVE;
      new_rsp.light = mem_q_ff.light;
      new_rsp.level = lvl_ext[7:0];
      new_rsp.pwm   = !fin && fade;
      if (fin) begin
         new_rsp.status = (mem_q_ff.target == TGT_OFF || mem_q_ff.target == TGT_FADE_OFF)
                          ? STS_OFF : STS_ON;
      end else begin
         new_rsp.status = mem_q_ff.target;
      end
      new_rsp.count = 5'(count_ff + 1'b1);
   end

   assign req_evt.t_start = req_start_time;
   assign req_evt.t_stop  = req_end_time;
   assign req_evt.light   = req_light_index;
   assign req_evt.target  = req_target;

   always_comb begin
      mem_we = 1'b0;
      mem_wa = w_ff[IW-1:0];
      mem_wd = mem_q_ff;
      if (state_ff == ST_IDLE && req_take && req_action == ACT_SCHED
          && len_ff < CW'(EVENT_DEPTH)) begin
         mem_we = 1'b1;
         mem_wa = len_ff[IW-1:0];
         mem_wd = req_evt;
      end else if (state_ff == ST_EV && r_ff != len_ff && !started) begin
         mem_we = 1'b1;
      end else if (push_go && !drop) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (state_ff == ST_RD) begin
         mem_q_ff <= mem[r_ff[IW-1:0]];
      end
   end

   tlfs_div #(.QW(QW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == ST_DIVS),
      .num   (num_ff),
      .den   (span_ff),
      .ctl   (div_ctl),
      .quo   (quo)
   );

   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL) begin
         num_ff  <= {{QW{1'b0}}, now_ff - mem_q_ff.t_start} * {32'd0, LMAX};
         span_ff <= mem_q_ff.t_stop - mem_q_ff.t_start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         len_ff        <= '0;
         r_ff          <= '0;
         w_ff          <= '0;
         count_ff      <= '0;
         head_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         out_last_ff   <= 1'b0;
      end else begin
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  case (req_action)
                     ACT_SCHED: begin
                        pend_valid_ff <= 1'b1;
                        if (len_ff < CW'(EVENT_DEPTH)) begin
                           pend_ff <= kind_only(KIND_SCHEDULED);
                           w_ff    <= len_ff + 1'b1;
                        end else begin
                           pend_ff <= kind_only(KIND_REJECTED);
                           w_ff    <= len_ff;
                        end
                        state_ff <= ST_FIN;
                     end
                     ACT_CLEAR: begin
                        pend_valid_ff <= 1'b1;
                        pend_ff       <= kind_only(KIND_CLEARED);
                        w_ff          <= '0;
                        state_ff      <= ST_FIN;
                     end
                     ACT_UPDATE: begin
                        pend_valid_ff <= 1'b0;
                        now_ff        <= req_now;
                        r_ff          <= '0;
                        w_ff          <= '0;
                        count_ff      <= '0;
                        head_ff       <= 1'b1;
                        state_ff      <= ST_RD;
                     end
                     default: begin
                        pend_valid_ff <= 1'b0;
                     end
                  endcase
               end
            end
            ST_RD: begin
               state_ff <= ST_EV;
            end
            ST_EV: begin
               if (r_ff == len_ff) begin
                  state_ff <= ST_FIN;
               end else if (!started) begin
                  w_ff     <= w_ff + 1'b1;
                  r_ff     <= r_ff + 1'b1;
                  head_ff  <= 1'b0;
                  state_ff <= ST_RD;
               end else if (!fin && fade) begin
                  state_ff <= ST_MUL;
               end else begin
                  state_ff <= ST_PUSH;
               end
            end
            ST_MUL: begin
               state_ff <= ST_DIVS;
            end
            ST_DIVS: begin
               state_ff <= ST_DIVW;
            end
            ST_DIVW: begin
               if (div_ctl.done) begin
                  state_ff <= ST_PUSH;
               end
            end
            ST_PUSH: begin
               if (push_go) begin
                  if (pend_valid_ff) begin
                     out_ff      <= pend_ff;
                     out_last_ff <= 1'b0;
                  end
                  pend_ff       <= new_rsp;
                  pend_valid_ff <= 1'b1;
                  count_ff      <= count_ff + 1'b1;
                  if (!drop) begin
                     w_ff    <= w_ff + 1'b1;
                     head_ff <= 1'b0;
                  end
                  r_ff     <= r_ff + 1'b1;
                  state_ff <= ST_RD;
               end
            end
            ST_FIN: begin
               if (out_free) begin
                  out_ff        <= pend_valid_ff ? pend_ff : kind_only(KIND_NONE);
                  out_last_ff   <= 1'b1;
                  pend_valid_ff <= 1'b0;
                  len_ff        <= w_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = out_ff.kind;
   assign rsp_drive_light    = out_ff.light;
   assign rsp_drive_level    = out_ff.level;
   assign rsp_is_pwm         = out_ff.pwm;
   assign rsp_light_status   = out_ff.status;
   assign rsp_executed_count = out_ff.count;
   assign rsp_last           = out_last_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= CW'(EVENT_DEPTH))
      else $error("queue length past depth");

   a_compact: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EV || state_ff == ST_PUSH) |-> (w_ff <= r_ff && r_ff <= len_ff))
      else $error("write index ahead of read index");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_action != ACT_SCHED && req_action != ACT_UPDATE
       && req_action != ACT_CLEAR) |=> state_ff == ST_IDLE)
      else $error("unused action started work");

endmodule

>>> rtl/tlfs_div.sv
// Restoring divider, one quotient bit per cycle; quotient known to fit QW bits.
module tlfs_div #(
   parameter int QW = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [31+QW:0]       num,
   input  logic [31:0]          den,
   output tlfs_pkg::div_ctl_type ctl,
   output logic [QW-1:0]        quo
);
   import tlfs_pkg::*;

   localparam int CNTW = $clog2(QW + 1);

   logic [31:0]   rem_ff;
   logic [QW-1:0] sh_ff;
   logic [QW-1:0] quo_ff;
   logic [CNTW-1:0] cnt_ff;
   logic          busy_ff;
   logic [32:0]   trial;
   logic          fits;

   assign trial = {rem_ff, sh_ff[QW-1]};
   assign fits  = trial >= {1'b0, den};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNTW'(QW);
         rem_ff  <= num[31+QW:QW];
         sh_ff   <= num[QW-1:0];
         quo_ff  <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? 32'(trial - {1'b0, den}) : trial[31:0];
         sh_ff  <= sh_ff << 1;
         quo_ff <= QW'({quo_ff, fits});
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign ctl.start = start;
   assign ctl.done  = !busy_ff && !start;
   assign quo       = quo_ff;

endmodule
